/* hw/rtl/assert_macros.svh */
// assertion helpers for the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, off while reset is held
`define OAS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked property, checked during reset too
`define OAS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* hw/rtl/oas_pkg.sv */
package oas_pkg;

    localparam int SLOT_COUNT = 5;
    localparam int DIST_W     = 10;
    localparam int SPEED_W    = 8;
    localparam int TICK_W     = 16;
    localparam int NUM_W      = DIST_W + SPEED_W;
    localparam int DIV_STEPS  = NUM_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

    typedef logic [DIST_W-1:0]  t_dist;
    typedef logic [SPEED_W-1:0] t_speed;
    typedef logic [TICK_W-1:0]  t_ticks;

    typedef enum logic [2:0] {
        MODE_START    = 3'd0,
        MODE_FORWARD  = 3'd1,
        MODE_OBSTACLE = 3'd2,
        MODE_ROTATE   = 3'd3,
        MODE_BLOCKED  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        CMD_STOP    = 2'd0,
        CMD_FORWARD = 2'd1,
        CMD_LEFT    = 2'd2,
        CMD_RIGHT   = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ANG_0   = 3'd0,
        ANG_30  = 3'd1,
        ANG_90  = 3'd2,
        ANG_150 = 3'd3,
        ANG_180 = 3'd4
    } t_angle;

    typedef enum logic [2:0] {
        CFG_MIN_DIST      = 3'd0,
        CFG_MAX_DIST      = 3'd1,
        CFG_UPDATE_IVAL   = 3'd2,
        CFG_ROT90_TIME    = 3'd3,
        CFG_ROT180_TIME   = 3'd4,
        CFG_ROT_SPEED     = 3'd5,
        CFG_MIN_LIN_SPEED = 3'd6
    } t_cfg_idx;

    localparam t_speed SPEED_TOP        = 8'd255;
    localparam t_dist  MIN_DIST_RST     = 10'd20;
    localparam t_dist  MAX_DIST_RST     = 10'd200;
    localparam t_ticks UPDATE_IVAL_RST  = 16'd100;
    localparam t_ticks ROT90_RST        = 16'd400;
    localparam t_ticks ROT180_RST       = 16'd800;
    localparam t_speed ROT_SPEED_RST    = 8'd150;
    localparam t_speed MIN_LIN_SPD_RST  = 8'd100;
    localparam t_ticks TICK_MAX         = 16'hFFFF;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic calc;
        logic mul;
        logic div_step;
        logic div_end;
        logic out_load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_div;
    } t_dp_status;

    typedef struct packed {
        t_cmd   motor_command;
        t_speed motor_speed;
        t_angle scanner_angle;
        t_mode  mode_now;
        logic   step_taken;
    } t_result;

    // next scanner position: 90/150/90/30 and 90/180/90/0 sweeps
    function automatic t_angle scan_next(input t_angle here, input t_angle prior);
        t_angle nxt;
        nxt = here;
        if (here != ANG_90) begin
            nxt = ANG_90;
        end else if (prior == ANG_150) begin
            nxt = ANG_30;
        end else if (prior == ANG_30) begin
            nxt = ANG_150;
        end else if (prior == ANG_180) begin
            nxt = ANG_0;
        end else if (prior == ANG_0) begin
            nxt = ANG_180;
        end
        return nxt;
    endfunction

endpackage

/* hw/rtl/oas_if.sv */
interface oas_in_if;
    logic                valid;
    logic                ready;
    oas_pkg::t_dist      range_reading;

    modport source (output valid, output range_reading, input ready);
    modport sink   (input valid, input range_reading, output ready);
endinterface

interface oas_out_if;
    logic                valid;
    logic                ready;
    logic [1:0]          motor_command;
    oas_pkg::t_speed     motor_speed;
    logic [2:0]          scanner_angle;
    logic [2:0]          mode_now;
    logic                step_taken;

    modport source (output valid, output motor_command, output motor_speed,
                    output scanner_angle, output mode_now, output step_taken,
                    input ready);
    modport sink   (input valid, input motor_command, input motor_speed,
                    input scanner_angle, input mode_now, input step_taken,
                    output ready);
endinterface

interface oas_cfg_if;
    logic                valid;
    logic                ready;
    logic [2:0]          cfg_index;
    oas_pkg::t_ticks     cfg_data;

    modport source (output valid, output cfg_index, output cfg_data, input ready);
    modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

/* hw/rtl/obstacle_avoidance_sequencer_top.sv */
// channel   dir  handshake      payload
// i_in      in   valid/ready    range_reading[9:0]
// o_out     out  valid/ready    motor_command, motor_speed, scanner_angle, mode_now, step_taken
// i_cfg     in   valid/ready    cfg_index[2:0], cfg_data[15:0]
//
// an item passes calc then done from accept to result when no speed division is
// needed, and calc, mul, div, fin, done when forward speed uses the 18-step serial divider
// one item is in flight at a time; the next is taken once the result is
// registered, even while that result waits for o_out.ready
// reset is synchronous, active low; configuration writes are ready whenever
// reset is released
module obstacle_avoidance_sequencer_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    oas_in_if.sink    i_in,
    oas_out_if.source o_out,
    oas_cfg_if.sink   i_cfg
);
    import oas_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status sts;
    t_result    result;

    assign i_cfg.ready = i_rst_n;

    // controller
    oas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // datapath
    oas_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_reading   (i_in.range_reading),
        .i_cfg_wr    (i_cfg.valid),
        .i_cfg_index (i_cfg.cfg_index),
        .i_cfg_data  (i_cfg.cfg_data),
        .o_result    (result)
    );

    // result fields onto the output channel
    assign o_out.motor_command = result.motor_command;
    assign o_out.motor_speed   = result.motor_speed;
    assign o_out.scanner_angle = result.scanner_angle;
    assign o_out.mode_now      = result.mode_now;
    assign o_out.step_taken    = result.step_taken;

endmodule

/* hw/rtl/oas_ctrl.sv */
`include "assert_macros.svh"

module oas_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    input  oas_pkg::t_dp_status i_sts,
    output oas_pkg::t_ctrl_cmd  o_cmd
);
    import oas_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC,
        S_MUL,
        S_DIV,
        S_FIN,
        S_DONE
    } t_state;

    t_state               r_state;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_out_valid;
    logic                 in_acc;
    logic                 out_free;

    assign o_in_ready  = (r_state == S_IDLE) && i_rst_n;
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // commands per state
    always_comb begin
        o_cmd          = '0;
        o_cmd.load     = in_acc;
        o_cmd.calc     = (r_state == S_CALC);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.div_step = (r_state == S_DIV);
        o_cmd.div_end  = (r_state == S_FIN);
        o_cmd.out_load = (r_state == S_DONE) && out_free;
    end

    // sequencer and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // set when a result is loaded, cleared when it is taken
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_state <= i_sts.need_div ? S_MUL : S_DONE;
                end
                S_MUL: begin
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `OAS_ASSERT(a_acc_to_calc, i_clk, i_rst_n, in_acc |=> (r_state == S_CALC), "accepted item did not start a calc")
    `OAS_ASSERT(a_div_len, i_clk, i_rst_n, (r_state == S_DIV) && (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) |=> (r_state == S_FIN), "divider did not end after its last step")
    `OAS_ASSERT(a_valid_src, i_clk, i_rst_n, $rose(r_out_valid) |-> $past(r_state == S_DONE), "result shown without finishing an item")

endmodule

/* hw/rtl/oas_dp.sv */
module oas_dp (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  oas_pkg::t_ctrl_cmd  i_cmd,
    output oas_pkg::t_dp_status o_sts,
    input  oas_pkg::t_dist      i_reading,
    input  logic                i_cfg_wr,
    input  logic [2:0]          i_cfg_index,
    input  oas_pkg::t_ticks     i_cfg_data,
    output oas_pkg::t_result    o_result
);
    import oas_pkg::*;

    // configuration registers
    t_dist  r_min_dist;
    t_dist  r_max_dist;
    t_ticks r_upd_ival;
    t_ticks r_rot90;
    t_ticks r_rot180;
    t_speed r_rot_speed;
    t_speed r_min_lin;

    // block state
    t_mode  r_mode;
    t_dist  r_slots [SLOT_COUNT];
    t_angle r_angle;
    t_angle r_prior;
    t_ticks r_ival;
    t_ticks r_elapsed;
    t_cmd   r_motor;
    t_speed r_speed;
    logic   r_stepped;

    // item and divider registers
    t_dist            r_reading;
    t_dist            r_diff;
    t_speed           r_scale;
    t_dist            r_den;
    logic [NUM_W-1:0] r_num;
    logic [DIST_W:0]  r_rem;
    t_result          r_result;

    // step logic
    t_ticks elapsed_inc;
    logic   stepped;
    t_dist  clip;
    t_dist  slots_w [SLOT_COUNT];
    t_dist  slots_n [SLOT_COUNT];
    t_mode  n_mode;
    t_angle n_angle;
    t_angle n_prior;
    t_ticks n_ival;
    t_cmd   n_motor;
    t_speed n_speed;
    logic   need_div;
    logic   fwd_speed;
    logic   spd_sat;
    t_dist  d_clamp;
    t_dist  front;

    // divider step
    logic [DIST_W:0] trial;
    logic            fits;

    assign elapsed_inc = (r_elapsed != TICK_MAX) ? r_elapsed + 1'b1 : r_elapsed;
    assign stepped     = (elapsed_inc >= r_ival);
    assign clip        = (r_reading > r_max_dist) ? r_max_dist : r_reading;

    always_comb begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
            slots_w[i] = (r_angle == 3'(i)) ? clip : r_slots[i];
        end
    end

    assign front   = slots_w[2];
    assign spd_sat = (r_max_dist <= r_min_dist) || (front >= r_max_dist);
    assign d_clamp = (front < r_min_dist) ? r_min_dist : front;

    // mode machine for one scan step
    always_comb begin
        slots_n   = slots_w;
        n_mode    = r_mode;
        n_angle   = r_angle;
        n_prior   = r_prior;
        n_ival    = r_ival;
        n_motor   = r_motor;
        n_speed   = r_speed;
        fwd_speed = 1'b0;
        unique case (r_mode)
            MODE_START: begin
                n_prior = r_angle;
                n_ival  = r_upd_ival;
                if (front >= r_min_dist) begin
                    n_angle   = scan_next(r_angle, ANG_30);
                    n_motor   = CMD_FORWARD;
                    fwd_speed = 1'b1;
                    n_mode    = MODE_FORWARD;
                end else begin
                    n_angle = scan_next(r_angle, ANG_0);
                    n_motor = CMD_STOP;
                    n_speed = '0;
                    n_mode  = MODE_OBSTACLE;
                end
            end
            MODE_FORWARD: begin
                if (front < r_min_dist) begin
                    n_angle = scan_next(r_angle, ANG_0);
                    n_prior = r_angle;
                    n_motor = CMD_STOP;
                    n_speed = '0;
                    n_mode  = MODE_OBSTACLE;
                    n_ival  = r_upd_ival;
                end else if (slots_w[1] < r_min_dist) begin
                    if (r_motor != CMD_LEFT) begin
                        n_motor = CMD_LEFT;
                        n_speed = r_rot_speed;
                    end
                    n_ival = '0;
                end else if (slots_w[3] < r_min_dist) begin
                    if (r_motor != CMD_RIGHT) begin
                        n_motor = CMD_RIGHT;
                        n_speed = r_rot_speed;
                    end
                    n_ival = '0;
                end else begin
                    n_angle   = scan_next(r_angle, r_prior);
                    n_prior   = r_angle;
                    n_motor   = CMD_FORWARD;
                    fwd_speed = 1'b1;
                    n_ival    = r_upd_ival;
                end
            end
            MODE_OBSTACLE: begin
                n_angle = scan_next(r_angle, r_prior);
                n_prior = r_angle;
                if (r_angle == ANG_0) begin
                    if (slots_w[0] < r_min_dist && slots_w[2] < r_min_dist &&
                        slots_w[4] < r_min_dist) begin
                        n_mode = MODE_BLOCKED;
                    end else begin
                        n_mode = MODE_ROTATE;
                    end
                end
            end
            MODE_ROTATE, MODE_BLOCKED: begin
                n_motor    = (slots_w[0] < slots_w[4]) ? CMD_LEFT : CMD_RIGHT;
                n_speed    = r_rot_speed;
                n_ival     = (r_mode == MODE_ROTATE) ? r_rot90 : r_rot180;
                n_mode     = MODE_START;
                slots_n[1] = r_max_dist;
                slots_n[3] = r_max_dist;
            end
            default: begin
                n_mode = r_mode;
            end
        endcase
        // linear speed: saturated directly, otherwise through the divider
        need_div = 1'b0;
        if (fwd_speed) begin
            if (spd_sat) begin
                n_speed = SPEED_TOP;
            end else begin
                need_div = 1'b1;
            end
        end
    end

    assign o_sts.need_div = stepped && need_div;

    assign trial = {r_rem[DIST_W-1:0], r_num[NUM_W-1]};
    assign fits  = (trial >= {1'b0, r_den});

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_dist  <= MIN_DIST_RST;
            r_max_dist  <= MAX_DIST_RST;
            r_upd_ival  <= UPDATE_IVAL_RST;
            r_rot90     <= ROT90_RST;
            r_rot180    <= ROT180_RST;
            r_rot_speed <= ROT_SPEED_RST;
            r_min_lin   <= MIN_LIN_SPD_RST;
        end else if (i_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_MIN_DIST:      r_min_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_MAX_DIST:      r_max_dist  <= i_cfg_data[DIST_W-1:0];
                CFG_UPDATE_IVAL:   r_upd_ival  <= i_cfg_data;
                CFG_ROT90_TIME:    r_rot90     <= i_cfg_data;
                CFG_ROT180_TIME:   r_rot180    <= i_cfg_data;
                CFG_ROT_SPEED:     r_rot_speed <= i_cfg_data[SPEED_W-1:0];
                CFG_MIN_LIN_SPEED: r_min_lin   <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // block state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode    <= MODE_START;
            r_angle   <= ANG_90;
            r_prior   <= ANG_90;
            r_ival    <= UPDATE_IVAL_RST;
            r_elapsed <= '0;
            r_motor   <= CMD_STOP;
            r_speed   <= '0;
            r_stepped <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slots[i] <= MAX_DIST_RST;
            end
        end else if (i_cmd.calc) begin
            r_stepped <= stepped;
            if (stepped) begin
                r_elapsed <= '0;
                r_mode    <= n_mode;
                r_angle   <= n_angle;
                r_prior   <= n_prior;
                r_ival    <= n_ival;
                r_motor   <= n_motor;
                r_speed   <= n_speed;
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    r_slots[i] <= slots_n[i];
                end
            end else begin
                r_elapsed <= elapsed_inc;
            end
        end else if (i_cmd.div_end) begin
            r_speed <= r_min_lin + r_num[SPEED_W-1:0];
        end
    end

    // item latch, divider operands and restoring divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_reading <= i_reading;
        end
        if (i_cmd.calc) begin
            r_diff  <= d_clamp - r_min_dist;
            r_scale <= SPEED_TOP - r_min_lin;
            r_den   <= r_max_dist - r_min_dist;
        end
        if (i_cmd.mul) begin
            r_num <= {{SPEED_W{1'b0}}, r_diff} * {{DIST_W{1'b0}}, r_scale};
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= fits ? (trial - {1'b0, r_den}) : trial;
            r_num <= {r_num[NUM_W-2:0], fits};
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_result.motor_command <= r_motor;
            r_result.motor_speed   <= r_speed;
            r_result.scanner_angle <= r_angle;
            r_result.mode_now      <= r_mode;
            r_result.step_taken    <= r_stepped;
        end
    end

    assign o_result = r_result;

endmodule
